/* sv/prhb_pkg.sv */
// ----------------------------------------------------------------------------
// prhb_pkg
// types and constants shared by the retransmit history buffer modules
// ----------------------------------------------------------------------------
package prhb_pkg;

	localparam logic [1:0] REQ_PACKET  = 2'd0;
	localparam logic [1:0] REQ_RETX    = 2'd1;
	localparam logic [1:0] REQ_FLUSH   = 2'd2;

	localparam logic [7:0] MAX_PACKETS_RESET = 8'd100;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] seq_num;
		logic        seq_given;
		logic [15:0] packet_handle;
	} prhb_in_t;

	typedef struct packed {
		logic [15:0] out_handle;
		logic [15:0] out_seq;
		logic        is_retransmit;
		logic        last;
	} prhb_out_t;

	typedef struct packed {
		logic [15:0] seq;
		logic [15:0] handle;
	} prhb_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_EMIT_RD,
		ST_EMIT_WR,
		ST_EMIT_LAST
	} prhb_state_t;

	typedef struct packed {
		logic load_in;
		logic hist_push;
		logic flush;
		logic scan_start;
		logic scan_step;
		logic pend_push;
		logic emit_start;
		logic pend_read;
		logic out_load_pend;
		logic out_load_pkt;
	} prhb_cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       seq_given;
		logic       hist_empty;
		logic       pend_empty;
		logic       pend_full;
		logic       idx_zero;
		logic       out_free;
		logic       hit;
		logic       scan_done;
	} prhb_sts_t;

endpackage

/* sv/packet_retransmit_history_buffer.sv */
// ----------------------------------------------------------------------------
// packet_retransmit_history_buffer
// ring of recent packets with a queue of requested resends
// ----------------------------------------------------------------------------
// one item at a time; a packet gives its queued resends and then the new packet,
// each step waiting while the output is full; a request searches the history
// from the newest entry and stops on a hit or when all entries are searched,
// and does not search when no number is given, the history is empty or the
// resend queue is full
// reset clears history count, newest pointer, pending count, output valid and
// sets the limit to 100; the memories are not cleared
// ----------------------------------------------------------------------------
module packet_retransmit_history_buffer #(
	parameter int HISTORY_DEPTH = 128,
	parameter int PENDING_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	// input items: packet, resend request or flush
	input  logic                req_valid,
	output logic                req_ready,
	input  prhb_pkg::prhb_in_t  req_item,
	// result items: queued resends first, new packet last
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output prhb_pkg::prhb_out_t rsp_item,
	// history limit register, always ready
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_data
);

	prhb_pkg::prhb_cmd_t cmd;
	prhb_pkg::prhb_sts_t sts;

	// register writes land at once, the port never stalls
	assign cfg_ready = 1'b1;

	// sequencer: decodes the captured item and steps the datapath
	prhb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: history ring, pending store, search compare, output register
	prhb_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.PENDING_DEPTH (PENDING_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_item  (req_item),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_item  (rsp_item),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

/* sv/prhb_ctrl.sv */
// ----------------------------------------------------------------------------
// prhb_ctrl
// sequencer for packet insert, resend emission, history search and flush
// ----------------------------------------------------------------------------
module prhb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  prhb_pkg::prhb_sts_t sts,
	output prhb_pkg::prhb_cmd_t cmd
);

	prhb_pkg::prhb_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prhb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			prhb_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_in = 1'b1;
					state_d     = prhb_pkg::ST_DECODE;
				end
			end
			prhb_pkg::ST_DECODE: begin
				state_d = prhb_pkg::ST_IDLE;
				case (sts.req_type)
					prhb_pkg::REQ_PACKET: begin
						cmd.hist_push = 1'b1;
						if (sts.pend_empty) begin
							state_d = prhb_pkg::ST_EMIT_LAST;
						end else begin
							cmd.emit_start = 1'b1;
							state_d        = prhb_pkg::ST_EMIT_RD;
						end
					end
					prhb_pkg::REQ_RETX: begin
						if (sts.seq_given && !sts.pend_full && !sts.hist_empty) begin
							cmd.scan_start = 1'b1;
							state_d        = prhb_pkg::ST_SCAN;
						end
					end
					prhb_pkg::REQ_FLUSH: begin
						cmd.flush = 1'b1;
					end
					default: begin
						state_d = prhb_pkg::ST_IDLE;
					end
				endcase
			end
			prhb_pkg::ST_SCAN: begin
				if (sts.hit) begin
					cmd.pend_push = 1'b1;
					state_d       = prhb_pkg::ST_IDLE;
				end else if (sts.scan_done) begin
					state_d = prhb_pkg::ST_IDLE;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			prhb_pkg::ST_EMIT_RD: begin
				cmd.pend_read = 1'b1;
				state_d       = prhb_pkg::ST_EMIT_WR;
			end
			prhb_pkg::ST_EMIT_WR: begin
				if (sts.out_free) begin
					cmd.out_load_pend = 1'b1;
					state_d = sts.idx_zero ? prhb_pkg::ST_EMIT_LAST : prhb_pkg::ST_EMIT_RD;
				end
			end
			prhb_pkg::ST_EMIT_LAST: begin
				if (sts.out_free) begin
					cmd.out_load_pkt = 1'b1;
					state_d          = prhb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = prhb_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* sv/prhb_dp.sv */
// ----------------------------------------------------------------------------
// prhb_dp
// history ring, pending store, search pipeline and output register
// ----------------------------------------------------------------------------
module prhb_dp #(
	parameter int HISTORY_DEPTH = 128,
	parameter int PENDING_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  prhb_pkg::prhb_in_t  req_item,
	input  logic                cfg_valid,
	input  logic [7:0]          cfg_data,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output prhb_pkg::prhb_out_t rsp_item,
	input  prhb_pkg::prhb_cmd_t cmd,
	output prhb_pkg::prhb_sts_t sts
);

	localparam int PW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CW = $clog2(HISTORY_DEPTH + 1);
	localparam int LW = (CW > 8) ? CW : 8;
	localparam int QW = $clog2(PENDING_DEPTH + 1);
	localparam int IW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

	logic [7:0]          max_packets_q;
	prhb_pkg::prhb_in_t  in_q;
	logic [PW-1:0]       newest_q;
	logic [CW-1:0]       hist_count_q;
	logic [QW-1:0]       pend_count_q;
	logic [IW-1:0]       idx_q;
	logic [PW-1:0]       scan_slot_q;
	logic [CW-1:0]       scan_left_q;
	logic                cmp_v_s1;
	prhb_pkg::prhb_entry_t hist_rd_s1;
	prhb_pkg::prhb_entry_t pend_rd_q;
	logic                rsp_valid_q;
	prhb_pkg::prhb_out_t rsp_item_q;

	prhb_pkg::prhb_entry_t hist_mem [HISTORY_DEPTH];
	prhb_pkg::prhb_entry_t pend_mem [PENDING_DEPTH];

	logic [LW-1:0] max_ext;
	logic [CW-1:0] limit;
	logic [CW:0]   count_inc;
	logic [PW-1:0] newest_inc;
	logic [PW-1:0] slot_dec;
	logic          out_free;

	// effective limit: zero or oversize means full ring
	always_comb begin
		max_ext = LW'(max_packets_q);
		if (max_ext == '0 || max_ext > LW'(HISTORY_DEPTH)) begin
			limit = CW'(HISTORY_DEPTH);
		end else begin
			limit = CW'(max_ext);
		end
	end

	assign count_inc  = {1'b0, hist_count_q} + (CW+1)'(1);
	assign newest_inc = (newest_q == PW'(HISTORY_DEPTH - 1)) ? '0 : newest_q + PW'(1);
	assign slot_dec   = (scan_slot_q == '0) ? PW'(HISTORY_DEPTH - 1) : scan_slot_q - PW'(1);
	assign out_free   = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_packets_q <= prhb_pkg::MAX_PACKETS_RESET;
			newest_q      <= '0;
			hist_count_q  <= '0;
			pend_count_q  <= '0;
			cmp_v_s1      <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				max_packets_q <= cfg_data;
			end
			if (cmd.hist_push) begin
				newest_q <= newest_inc;
				if (count_inc > {1'b0, limit}) begin
					hist_count_q <= limit;
				end else begin
					hist_count_q <= count_inc[CW-1:0];
				end
			end
			if (cmd.flush) begin
				hist_count_q <= '0;
				pend_count_q <= '0;
			end
			if (cmd.scan_start || cmd.pend_push) begin
				cmp_v_s1 <= 1'b0;
			end else if (cmd.scan_step) begin
				cmp_v_s1 <= (scan_left_q != '0);
			end
			if (cmd.pend_push) begin
				pend_count_q <= pend_count_q + QW'(1);
			end
			if (cmd.out_load_pkt) begin
				pend_count_q <= '0;
			end
			if (cmd.out_load_pend || cmd.out_load_pkt) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_q <= req_item;
		end
		if (cmd.scan_start) begin
			scan_slot_q <= newest_q;
			scan_left_q <= hist_count_q;
		end else if (cmd.scan_step && scan_left_q != '0) begin
			scan_slot_q <= slot_dec;
			scan_left_q <= scan_left_q - CW'(1);
		end
		if (cmd.emit_start) begin
			idx_q <= IW'(pend_count_q - QW'(1));
		end else if (cmd.out_load_pend) begin
			idx_q <= idx_q - IW'(1);
		end
		if (cmd.out_load_pend) begin
			rsp_item_q.out_handle    <= pend_rd_q.handle;
			rsp_item_q.out_seq       <= pend_rd_q.seq;
			rsp_item_q.is_retransmit <= 1'b1;
			rsp_item_q.last          <= 1'b0;
		end else if (cmd.out_load_pkt) begin
			rsp_item_q.out_handle    <= in_q.packet_handle;
			rsp_item_q.out_seq       <= in_q.seq_num;
			rsp_item_q.is_retransmit <= 1'b0;
			rsp_item_q.last          <= 1'b1;
		end
	end

	// history ring, one write port and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.hist_push) begin
			hist_mem[newest_inc] <= '{seq: in_q.seq_num, handle: in_q.packet_handle};
		end
		if (cmd.scan_step && scan_left_q != '0) begin
			hist_rd_s1 <= hist_mem[scan_slot_q];
		end
	end

	// pending store, kept in request order
	always_ff @(posedge clk) begin
		if (cmd.pend_push) begin
			pend_mem[pend_count_q[IW-1:0]] <= hist_rd_s1;
		end
		if (cmd.pend_read) begin
			pend_rd_q <= pend_mem[idx_q];
		end
	end

	always_comb begin
		sts.req_type   = in_q.req_type;
		sts.seq_given  = in_q.seq_given;
		sts.hist_empty = (hist_count_q == '0);
		sts.pend_empty = (pend_count_q == '0);
		sts.pend_full  = (pend_count_q == QW'(PENDING_DEPTH));
		sts.idx_zero   = (idx_q == '0);
		sts.out_free   = out_free;
		sts.hit        = cmp_v_s1 && (hist_rd_s1.seq == in_q.seq_num);
		sts.scan_done  = (scan_left_q == '0) && !cmp_v_s1;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// checks the retransmit history buffer: packets, resend requests and flushes
// are driven through the valid/ready input channel, the history limit is
// changed between phases, and every item leaving the block is matched in
// order against a model of the history ring and the resend queue kept here
// ----------------------------------------------------------------------------
module testbench;

	localparam int HISTORY_DEPTH = 128;
	localparam int PENDING_DEPTH = 16;
	// request type the block ignores
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	// longest quiet spell after the last result: a request scans the full ring
	localparam int SETTLE_CYCLES = 2 * HISTORY_DEPTH;
	localparam int LIMIT_CYCLES = 400000;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	// history ring and resend queue, plus the results they imply
	class retx_scoreboard;
		prhb_pkg::prhb_entry_t ring[HISTORY_DEPTH];
		int unsigned newest_slot;
		int unsigned history_count;
		prhb_pkg::prhb_entry_t resend_queue[$];
		logic [7:0]  limit_reg;
		prhb_pkg::prhb_out_t expected_sends[$];
		int unsigned mismatches;

		function new();
			newest_slot = 0;
			history_count = 0;
			limit_reg = prhb_pkg::MAX_PACKETS_RESET;
			mismatches = 0;
		endfunction

		function void set_limit(logic [7:0] value);
			limit_reg = value;
		endfunction

		// zero and anything past the ring mean the whole ring
		function int unsigned history_cap();
			if (limit_reg == 0 || limit_reg > HISTORY_DEPTH)
				return HISTORY_DEPTH;
			return limit_reg;
		endfunction

		function logic [15:0] seq_held_at(int unsigned age);
			return ring[(newest_slot + HISTORY_DEPTH - age) % HISTORY_DEPTH].seq;
		endfunction

		function void note_item(prhb_pkg::prhb_in_t it);
			int unsigned cap;
			int unsigned slot;
			prhb_pkg::prhb_entry_t e;
			case (it.req_type)
				prhb_pkg::REQ_PACKET: begin
					cap = history_cap();
					newest_slot = (newest_slot + 1) % HISTORY_DEPTH;
					ring[newest_slot] = '{seq: it.seq_num, handle: it.packet_handle};
					history_count = (history_count + 1 > cap) ? cap : history_count + 1;
					// latest request goes out first
					while (resend_queue.size() != 0) begin
						e = resend_queue.pop_back();
						expected_sends.push_back('{out_handle: e.handle, out_seq: e.seq,
							is_retransmit: 1'b1, last: 1'b0});
					end
					expected_sends.push_back('{out_handle: it.packet_handle,
						out_seq: it.seq_num, is_retransmit: 1'b0, last: 1'b1});
				end
				prhb_pkg::REQ_RETX: begin
					if (it.seq_given && resend_queue.size() < PENDING_DEPTH) begin
						for (int age = 0; age < history_count; age++) begin
							slot = (newest_slot + HISTORY_DEPTH - age) % HISTORY_DEPTH;
							if (ring[slot].seq == it.seq_num) begin
								resend_queue.push_back(ring[slot]);
								break;
							end
						end
					end
				end
				prhb_pkg::REQ_FLUSH: begin
					history_count = 0;
					resend_queue.delete();
				end
				default: begin
				end
			endcase
		endfunction

		function void compare_field(string field, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %h got %h", $time, field, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(prhb_pkg::prhb_out_t got);
			prhb_pkg::prhb_out_t want;
			if (expected_sends.size() == 0) begin
				$display("%0t: unexpected result, expected none got %h", $time, got);
				mismatches++;
				return;
			end
			want = expected_sends.pop_front();
			compare_field("out_handle", want.out_handle, got.out_handle);
			compare_field("out_seq", want.out_seq, got.out_seq);
			compare_field("is_retransmit", 16'(want.is_retransmit), 16'(got.is_retransmit));
			compare_field("last", 16'(want.last), 16'(got.last));
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_ready;
	prhb_pkg::prhb_in_t  req_item;
	logic                rsp_valid;
	logic                rsp_ready;
	prhb_pkg::prhb_out_t rsp_item;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [7:0]          cfg_data;

	retx_scoreboard sb = new();

	// percent chance per cycle of a sender gap or a receiver stall
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned cycle_count;
	logic [15:0] next_seq_num = 16'h0100;

	packet_retransmit_history_buffer #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.PENDING_DEPTH(PENDING_DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_item (req_item),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_item (rsp_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// handshakes are sampled at the falling edge, where everything is settled,
	// and take effect at the next rising edge

	// result side: random stalls, every accepted item goes to the scoreboard
	initial begin : result_monitor
		prhb_pkg::prhb_out_t seen;
		bit took;
		rsp_ready <= 1'b0;
		forever begin
			@(negedge clk);
			took = arst_n && rsp_valid && rsp_ready;
			seen = rsp_item;
			@(posedge clk);
			if (took)
				sb.check_result(seen);
			rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[packet_retransmit_history_buffer] ERROR");
		$finish;
	end

	function automatic prhb_pkg::prhb_in_t item_of(logic [1:0] kind, logic [15:0] seq,
		logic given, logic [15:0] handle);
		prhb_pkg::prhb_in_t it;
		it.req_type = kind;
		it.seq_num = seq;
		it.seq_given = given;
		it.packet_handle = handle;
		return it;
	endfunction

	// running numbers, a few tiny ones to make duplicates, the rest anything
	function automatic prhb_pkg::prhb_in_t random_packet();
		int unsigned roll;
		logic [15:0] seq;
		roll = $urandom_range(0, 3);
		if (roll < 2) begin
			seq = next_seq_num;
			next_seq_num = next_seq_num + 16'd1;
		end else if (roll == 2) begin
			seq = 16'($urandom_range(0, 7));
		end else begin
			seq = 16'($urandom_range(0, 65535));
		end
		return item_of(prhb_pkg::REQ_PACKET, seq, 1'($urandom_range(0, 1)),
			16'($urandom_range(0, 65535)));
	endfunction

	// mostly a number still held, at any depth, so the scan goes deep
	function automatic prhb_pkg::prhb_in_t random_request();
		logic [15:0] seq;
		logic given;
		if (sb.history_count != 0 && $urandom_range(0, 99) < 75)
			seq = sb.seq_held_at($urandom_range(0, sb.history_count - 1));
		else
			seq = 16'($urandom_range(0, 65535));
		given = ($urandom_range(0, 9) != 0);
		return item_of(prhb_pkg::REQ_RETX, seq, given, 16'($urandom_range(0, 65535)));
	endfunction

	// called at a rising edge; returns at the edge where the item is accepted
	task automatic send_item(input prhb_pkg::prhb_in_t it);
		bit fire;
		if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct);
		end
		req_item <= it;
		req_valid <= 1'b1;
		do begin
			@(negedge clk);
			fire = req_ready;
			@(posedge clk);
		end while (!fire);
		sb.note_item(it);
	endtask

	task automatic write_limit(input logic [7:0] value);
		bit fire;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do begin
			@(negedge clk);
			fire = cfg_ready;
			@(posedge clk);
		end while (!fire);
		cfg_valid <= 1'b0;
		sb.set_limit(value);
	endtask

	// all results in, then room for a scan that gives none
	task automatic wait_idle();
		req_valid <= 1'b0;
		while (sb.expected_sends.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_idle_mode(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct = 65;
				stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct = 0;
				stall_pct = 65;
			end
			default: begin
				send_idle_pct = 27;
				stall_pct = 27;
			end
		endcase
	endtask

	// groups are a lone packet or a burst of requests closed by a packet,
	// with some ignored items and flushes mixed in
	task automatic run_phase(input logic [7:0] limit_value, input idle_mode_t mode,
		input int target, input int burst_pct, input int max_burst, input bit flush_ok);
		int counted;
		int roll;
		wait_idle();
		write_limit(limit_value);
		set_idle_mode(mode);
		counted = 0;
		while (counted < target) begin
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				send_item(item_of(REQ_UNUSED, 16'($urandom_range(0, 65535)),
					1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535))));
			end else if (roll < 7 && flush_ok) begin
				send_item(item_of(prhb_pkg::REQ_FLUSH, 16'($urandom_range(0, 65535)),
					1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535))));
				counted++;
			end else begin
				if (roll < burst_pct) begin
					repeat ($urandom_range(1, max_burst)) begin
						send_item(random_request());
						counted++;
					end
				end
				send_item(random_packet());
				counted++;
			end
		end
	endtask

	initial begin : stimulus
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req_item <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under the reset limit
		// field extremes on two packets
		send_item(item_of(prhb_pkg::REQ_PACKET, 16'h0000, 1'b0, 16'h0000));
		send_item(item_of(prhb_pkg::REQ_PACKET, 16'hffff, 1'b1, 16'hffff));
		// hit on the newest entry
		send_item(item_of(prhb_pkg::REQ_RETX, 16'hffff, 1'b1, 16'h0000));
		// no number given: nothing can match
		send_item(item_of(prhb_pkg::REQ_RETX, 16'h0000, 1'b0, 16'hffff));
		// hit on the oldest entry
		send_item(item_of(prhb_pkg::REQ_RETX, 16'h0000, 1'b1, 16'h0000));
		// miss
		send_item(item_of(prhb_pkg::REQ_RETX, 16'h1234, 1'b1, 16'h0000));
		// fill the resend queue, the last request is dropped
		repeat (PENDING_DEPTH - 1)
			send_item(item_of(prhb_pkg::REQ_RETX, 16'hffff, 1'b1, 16'h5a5a));
		// packet with a full queue: the longest run of results
		send_item(item_of(prhb_pkg::REQ_PACKET, 16'h0005, 1'b0, 16'ha5a5));
		// ignored request type
		send_item(item_of(REQ_UNUSED, 16'hffff, 1'b1, 16'hffff));
		send_item(item_of(prhb_pkg::REQ_FLUSH, 16'h0005, 1'b1, 16'h0000));
		// history is empty after a flush
		send_item(item_of(prhb_pkg::REQ_RETX, 16'h0005, 1'b1, 16'h0000));

		// limit past the ring, then zero with enough packets to saturate,
		// then limits of 3, 128 and 1, the small ones trimming the history
		run_phase(8'd255, IDLE_NONE, 70, 15, 2, 1'b0);
		run_phase(8'd0, IDLE_SENDER, 90, 15, 2, 1'b0);
		run_phase(8'd3, IDLE_RECEIVER, 25, 60, 20, 1'b1);
		run_phase(8'd128, IDLE_BOTH, 25, 60, 20, 1'b1);
		run_phase(8'd1, IDLE_NONE, 15, 60, 20, 1'b1);

		wait_idle();
		if (sb.mismatches == 0)
			$display("[packet_retransmit_history_buffer] OK");
		else
			$display("[packet_retransmit_history_buffer] ERROR");
		$finish;
	end

endmodule
